// ===== rtl/corner_first_fit_rect_packer_defines.svh =====
// Assertion macros for the corner first-fit rectangle packer.
// Used by the top level, which has the assertions; needs clk and arst_n in scope.
`ifndef CORNER_FIRST_FIT_RECT_PACKER_DEFINES_SVH
`define CORNER_FIRST_FIT_RECT_PACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define CFRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CFRP_ASSERT_IMP(lbl, ante, cons, msg) \
	`CFRP_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define CFRP_ASSERT(lbl, prop, msg)
`define CFRP_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/cfrp_pkg.sv =====
// Package of the corner first-fit rectangle packer: sizes, item types, codes and states.
// Depends on nothing; used by the top level only.
`timescale 1ns / 1ps
`default_nettype none
package cfrp_pkg;
	localparam int MAX_PAGES   = 8;
	localparam int MAX_RECTS   = 32;
	localparam int MAX_CORNERS = 128;
	localparam int COORD_BITS  = 13;

	localparam int DIM_W   = 13;
	localparam int CFG_W   = 13;
	localparam int PAD_W   = 8;
	localparam int PAGE_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int PCNT_W  = $clog2(MAX_PAGES + 1);
	localparam int CIDX_W  = $clog2(MAX_CORNERS);
	localparam int CCNT_W  = $clog2(MAX_CORNERS + 1);
	localparam int RIDX_W  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int RCNT_W  = $clog2(MAX_RECTS + 1);
	localparam int SUM_W   = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;
	localparam int AREA_W  = 2 * DIM_W;
	localparam int ASUM_W  = AREA_W + 1;
	localparam int CADDR_W = PAGE_W + CIDX_W;
	localparam int RADDR_W = PAGE_W + RIDX_W;
	localparam int CDEPTH  = 2 ** CADDR_W;
	localparam int RDEPTH  = 2 ** RADDR_W;

	localparam logic CMD_CLEAR = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} corner_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t w;
		coord_t h;
	} rect_t;

	typedef enum logic [1:0] {
		REG_PAGE_WIDTH  = 2'd0,
		REG_PAGE_HEIGHT = 2'd1,
		REG_PAD         = 2'd2,
		REG_NONE        = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_PLACED  = 2'd0,
		ST_CLEARED = 2'd1,
		ST_NO_PAGE = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic        command;
		logic [11:0] rect_width;
		logic [11:0] rect_height;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [2:0]  page_index;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_AREA, S_PAREA, S_PAGE, S_CRD, S_CCHK, S_RRD, S_RCHK,
		S_FOUND, S_SRD, S_SWR, S_AP0, S_AP1, S_AP2, S_FIN
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/corner_first_fit_rect_packer.sv =====
// Top level of the corner first-fit rectangle packer: sequencer, page counters, two RAMs.
// Depends on cfrp_pkg, cfrp_ram and corner_first_fit_rect_packer_defines.svh.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_data (in_item_t)
// out      output     out_valid / out_ready out_data (out_item_t)
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// One item is worked on at a time. A placement tries the open pages in order, skipping
// one whose area would overflow, checks each fitting corner against the page's rectangles,
// then shifts later corners down and appends three, via the single read port of each RAM.
// Reset clears the page count and all fill counters at once; the RAMs need no clearing.
// A waiting result sits in the output register; only the next result stalls on it.
`timescale 1ns / 1ps
`default_nettype none
`include "corner_first_fit_rect_packer_defines.svh"
module corner_first_fit_rect_packer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire cfrp_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output cfrp_pkg::out_item_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [12:0]         cfg_wdata
);
	import cfrp_pkg::*;

	state_t state_q, state_d;

	logic [CFG_W-1:0]  pw_q, ph_q;
	logic [PAD_W-1:0]  pad_q;
	logic [PCNT_W-1:0] page_count_q;
	logic [CCNT_W-1:0] cfill_q [MAX_PAGES];
	logic [RCNT_W-1:0] rfill_q [MAX_PAGES];
	logic [AREA_W-1:0] asum_q [MAX_PAGES];

	logic [DIM_W-1:0]  w_q, h_q;
	logic [AREA_W-1:0] area_q, parea_q;
	logic [PCNT_W-1:0] p_q;
	logic [CCNT_W-1:0] c_q, n_q;
	logic [RCNT_W-1:0] k_q;
	coord_t            cx_q, cy_q;
	status_t           stat_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [PAGE_W-1:0] p_idx;
	logic [CCNT_W-1:0] cur_cfill;
	logic [RCNT_W-1:0] cur_rfill;
	logic [AREA_W-1:0] cur_asum;
	logic [DIM_W-1:0]  mul_a, mul_b;
	logic [AREA_W-1:0] prod;
	logic              page_skip, out_bound, overlap, store_full, fin_go;
	logic [SUM_W-1:0]  cx_w, cy_h, cx_w_q, cy_h_q, rx_w, ry_h;
	logic [$bits(corner_t)-1:0] c_rdata_w;
	logic [$bits(rect_t)-1:0]   r_rdata_w;
	corner_t           c_rd, c_wdata;
	rect_t             r_rd, r_wdata;
	logic              c_we;
	logic [CADDR_W-1:0] c_waddr, c_raddr;
	logic [RADDR_W-1:0] r_raddr;
	logic [DIM_W-1:0]  w_in, h_in;
	logic [CCNT_W-1:0] c_next;

	assign p_idx     = p_q[PAGE_W-1:0];
	assign cur_cfill = cfill_q[p_idx];
	assign cur_rfill = rfill_q[p_idx];
	assign cur_asum  = asum_q[p_idx];
	assign c_next    = c_q + CCNT_W'(1);

	assign w_in = DIM_W'(in_data.rect_width) + DIM_W'({pad_q, 1'b0});
	assign h_in = DIM_W'(in_data.rect_height) + DIM_W'({pad_q, 1'b0});

	assign mul_a = (state_q == S_AREA) ? w_q : pw_q;
	assign mul_b = (state_q == S_AREA) ? h_q : ph_q;
	assign prod  = AREA_W'(mul_a) * AREA_W'(mul_b);

	assign page_skip = (ASUM_W'(cur_asum) + ASUM_W'(area_q)) > ASUM_W'(parea_q);

	assign c_rd = corner_t'(c_rdata_w);
	assign r_rd = rect_t'(r_rdata_w);

	assign cx_w   = SUM_W'(c_rd.x) + SUM_W'(w_q);
	assign cy_h   = SUM_W'(c_rd.y) + SUM_W'(h_q);
	assign cx_w_q = SUM_W'(cx_q) + SUM_W'(w_q);
	assign cy_h_q = SUM_W'(cy_q) + SUM_W'(h_q);
	assign rx_w   = SUM_W'(r_rd.x) + SUM_W'(r_rd.w);
	assign ry_h   = SUM_W'(r_rd.y) + SUM_W'(r_rd.h);

	assign out_bound = (cx_w >= SUM_W'(pw_q)) || (cy_h >= SUM_W'(ph_q));
	assign overlap   = !((SUM_W'(r_rd.x) >= cx_w_q) || (rx_w <= SUM_W'(cx_q)) ||
		(SUM_W'(r_rd.y) >= cy_h_q) || (ry_h <= SUM_W'(cy_q)));
	assign store_full = ((CCNT_W + 1)'(cur_cfill) + (CCNT_W + 1)'(2) >
		(CCNT_W + 1)'(MAX_CORNERS)) || (cur_rfill >= RCNT_W'(MAX_RECTS));
	assign fin_go = !out_valid_q || out_ready;

	cfrp_ram #(.WIDTH($bits(corner_t)), .DEPTH(CDEPTH)) u_corner_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata_w)
	);

	cfrp_ram #(.WIDTH($bits(rect_t)), .DEPTH(RDEPTH)) u_rect_ram (
		.clk   (clk),
		.we    (state_q == S_AP0),
		.waddr ({p_idx, cur_rfill[RIDX_W-1:0]}),
		.wdata (r_wdata),
		.raddr (r_raddr),
		.rdata (r_rdata_w)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (in_data.command == CMD_CLEAR) ? S_FIN : S_AREA;
				end
			end
			S_AREA:  state_d = S_PAREA;
			S_PAREA: state_d = S_PAGE;
			S_PAGE: begin
				priority if (p_q == page_count_q) begin
					state_d = (page_count_q == PCNT_W'(MAX_PAGES)) ? S_FIN : S_AP0;
				end else if (page_skip) begin
					state_d = S_PAGE;
				end else begin
					state_d = S_CRD;
				end
			end
			S_CRD:  state_d = (c_q == cur_cfill) ? S_PAGE : S_CCHK;
			S_CCHK: state_d = out_bound ? S_CRD : S_RRD;
			S_RRD:  state_d = (k_q == cur_rfill) ? S_FOUND : S_RCHK;
			S_RCHK: state_d = overlap ? S_CRD : S_RRD;
			S_FOUND: begin
				priority if (store_full) begin
					state_d = S_FIN;
				end else if (c_next < cur_cfill) begin
					state_d = S_SRD;
				end else begin
					state_d = S_AP0;
				end
			end
			S_SRD: state_d = S_SWR;
			S_SWR: state_d = (c_next + CCNT_W'(1) < n_q) ? S_SRD : S_AP0;
			S_AP0: state_d = S_AP1;
			S_AP1: state_d = S_AP2;
			S_AP2: state_d = S_FIN;
			S_FIN: state_d = fin_go ? S_IDLE : S_FIN;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		c_we     = 1'b0;
		c_waddr  = {p_idx, c_q[CIDX_W-1:0]};
		c_wdata  = c_rd;
		c_raddr  = {p_idx, c_q[CIDX_W-1:0]};
		r_raddr  = {p_idx, k_q[RIDX_W-1:0]};
		r_wdata  = '{x: cx_q, y: cy_q, w: COORD_BITS'(w_q), h: COORD_BITS'(h_q)};
		unique case (state_q)
			S_SRD: c_raddr = {p_idx, c_next[CIDX_W-1:0]};
			S_SWR: c_we = 1'b1;
			S_AP0: begin
				c_we    = 1'b1;
				c_waddr = {p_idx, CIDX_W'(n_q - CCNT_W'(1))};
				c_wdata = '{x: COORD_BITS'(cx_w_q), y: cy_q};
			end
			S_AP1: begin
				c_we    = 1'b1;
				c_waddr = {p_idx, CIDX_W'(n_q)};
				c_wdata = '{x: cx_q, y: COORD_BITS'(cy_h_q)};
			end
			S_AP2: begin
				c_we    = 1'b1;
				c_waddr = {p_idx, CIDX_W'(n_q + CCNT_W'(1))};
				c_wdata = '{x: COORD_BITS'(cx_w_q), y: COORD_BITS'(cy_h_q)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pw_q         <= CFG_W'(1024);
			ph_q         <= CFG_W'(1024);
			pad_q        <= '0;
			page_count_q <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < MAX_PAGES; i++) begin
				cfill_q[i] <= '0;
				rfill_q[i] <= '0;
				asum_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_PAGE_WIDTH:  pw_q  <= cfg_wdata;
					REG_PAGE_HEIGHT: ph_q  <= cfg_wdata;
					REG_PAD:         pad_q <= cfg_wdata[PAD_W-1:0];
					REG_NONE: begin
					end
				endcase
			end
			if (state_q == S_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_data.command == CMD_CLEAR) begin
						page_count_q <= '0;
						for (int i = 0; i < MAX_PAGES; i++) begin
							cfill_q[i] <= '0;
							rfill_q[i] <= '0;
							asum_q[i]  <= '0;
						end
					end
				end
				S_PAGE: begin
					if (p_q == page_count_q && page_count_q != PCNT_W'(MAX_PAGES)) begin
						page_count_q   <= page_count_q + PCNT_W'(1);
						cfill_q[p_idx] <= CCNT_W'(1);
						rfill_q[p_idx] <= '0;
						asum_q[p_idx]  <= '0;
					end
				end
				S_AP2: begin
					cfill_q[p_idx] <= n_q + CCNT_W'(2);
					rfill_q[p_idx] <= cur_rfill + RCNT_W'(1);
					asum_q[p_idx]  <= AREA_W'(ASUM_W'(cur_asum) + ASUM_W'(area_q));
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				w_q    <= w_in;
				h_q    <= h_in;
				p_q    <= '0;
				stat_q <= ST_CLEARED;
			end
			S_AREA:  area_q  <= prod;
			S_PAREA: parea_q <= prod;
			S_PAGE: begin
				priority if (p_q == page_count_q) begin
					stat_q <= ST_NO_PAGE;
					cx_q   <= '0;
					cy_q   <= '0;
					c_q    <= '0;
					n_q    <= CCNT_W'(1);
				end else if (page_skip) begin
					p_q <= p_q + PCNT_W'(1);
				end else begin
					c_q <= '0;
				end
			end
			S_CRD: begin
				if (c_q == cur_cfill) begin
					p_q <= p_q + PCNT_W'(1);
				end
			end
			S_CCHK: begin
				cx_q <= c_rd.x;
				cy_q <= c_rd.y;
				k_q  <= '0;
				if (out_bound) begin
					c_q <= c_next;
				end
			end
			S_RRD: begin
			end
			S_RCHK: begin
				if (overlap) begin
					c_q <= c_next;
				end else begin
					k_q <= k_q + RCNT_W'(1);
				end
			end
			S_FOUND: begin
				stat_q <= ST_FULL;
				n_q    <= cur_cfill;
			end
			S_SWR: c_q <= c_next;
			S_AP2: stat_q <= ST_PLACED;
			S_FIN: begin
				if (fin_go) begin
					out_q.status <= stat_q;
					if (stat_q == ST_PLACED) begin
						out_q.page_index <= 3'(p_q);
						out_q.pos_x      <= 12'(cx_q + COORD_BITS'(pad_q));
						out_q.pos_y      <= 12'(cy_q + COORD_BITS'(pad_q));
					end else begin
						out_q.page_index <= '0;
						out_q.pos_x      <= '0;
						out_q.pos_y      <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`CFRP_ASSERT(a_page_count_max, page_count_q <= PCNT_W'(MAX_PAGES), "page count over limit")
	`CFRP_ASSERT(a_corner_fill_max, cur_cfill <= CCNT_W'(MAX_CORNERS), "corner fill over limit")
	`CFRP_ASSERT_IMP(a_shift_in_range, state_q == S_SRD, c_next < n_q, "shift past fill")
	`CFRP_ASSERT(a_result_held, out_valid_q && !out_ready |=> out_valid_q, "result dropped")
	`CFRP_ASSERT_IMP(a_scan_page, state_q == S_CRD, p_q < page_count_q, "scan of unopened page")
endmodule
`default_nettype wire

// ===== rtl/cfrp_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module cfrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
